@@ src/tga_pkg.sv @@
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types, codes and helper functions of the Targa pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_pkg;

   // pixel format codes
   localparam logic [2:0] FMT_GREY8    = 3'd0;
   localparam logic [2:0] FMT_GREY16   = 3'd1;
   localparam logic [2:0] FMT_ARGB1555 = 3'd2;
   localparam logic [2:0] FMT_BGR24    = 3'd3;
   localparam logic [2:0] FMT_BGRA32   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_RLE_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_PIXEL_COUNT  = 2'd2;

   // reset values
   localparam logic [2:0] FORMAT_RESET = FMT_BGR24;

   // packet decoding phase; the spare code acts as header
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_RUN    = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   // one decoded color
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   // what the packet parser hands on for one byte
   typedef struct packed {
      logic        emit;
      logic [2:0]  format;
      logic [31:0] pixel;
      logic [7:0]  repeat_cnt;
      logic        clipped;
      logic        last;
   } pix_result_type;

   // bytes per pixel of a format; unknown codes count as bgr24
   function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
      logic [2:0] n;
      unique case (fmt)
         FMT_GREY8:    n = 3'd1;
         FMT_GREY16:   n = 3'd2;
         FMT_ARGB1555: n = 3'd2;
         FMT_BGRA32:   n = 3'd4;
         default:      n = 3'd3;
      endcase
      return n;
   endfunction

   // floor(x * 255 / 31) as 8x plus a small correction floor(7x / 31)
   function automatic logic [7:0] scale5(input logic [4:0] x);
      logic [2:0] corr;
      corr = 3'(x >= 5'd5) + 3'(x >= 5'd9) + 3'(x >= 5'd14) + 3'(x >= 5'd18)
           + 3'(x >= 5'd23) + 3'(x >= 5'd27) + 3'(x >= 5'd31);
      return {x, 3'b000} + {5'b00000, corr};
   endfunction

endpackage

`default_nettype wire

@@ src/tga_rle_pixel_decoder.sv @@
// A byte that completes a pixel gives its result through the input register,
// then the result register.
// Throughput: one byte per cycle; the input register moves on whenever the
// result register is empty or being taken.
// Reset clears the valid flags, parser state and pixel counter and loads the
// configuration defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Targa pixel-data decoder: RLE packets, 1 to 4 byte pixels, RGBA results.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder
   import tga_pkg::*;
#(
   parameter int COUNT_BITS = 25
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [COUNT_BITS-1:0] csr_wdata,
   // byte input
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   // pixel output
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic [7:0]                 rsp_alpha,
   output logic [7:0]                 rsp_repeat_res,
   output logic                       rsp_clipped,
   output logic                       rsp_last
);

   logic [2:0]            fmt_ff;
   logic                  rle_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;

   logic                  out_valid_ff, out_valid_in;
   rgba_type              out_color_ff;
   logic [7:0]            out_repeat_ff;
   logic                  out_clipped_ff;
   logic                  out_last_ff;

   logic                  advance;
   logic                  req_take;
   pix_result_type        pres;
   rgba_type              color;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FORMAT_RESET;
         rle_ff   <= 1'b0;
         count_ff <= COUNT_BITS'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: fmt_ff   <= csr_wdata[2:0];
            CSR_RLE_ENABLE:   rle_ff   <= csr_wdata[0];
            CSR_PIXEL_COUNT:  count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && pres.emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // packet parser and gathering
   tga_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (in_byte_ff),
      .pixel_format (fmt_ff),
      .rle_enable   (rle_ff),
      .pixel_count  (count_ff),
      .result       (pres)
   );

   // color conversion
   tga_cvt u_cvt (
      .format (pres.format),
      .pixel  (pres.pixel),
      .color  (color)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pres.emit) begin
         out_color_ff   <= color;
         out_repeat_ff  <= pres.repeat_cnt;
         out_clipped_ff <= pres.clipped;
         out_last_ff    <= pres.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red        = out_color_ff.red;
   assign rsp_green      = out_color_ff.green;
   assign rsp_blue       = out_color_ff.blue;
   assign rsp_alpha      = out_color_ff.alpha;
   assign rsp_repeat_res = out_repeat_ff;
   assign rsp_clipped    = out_clipped_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

@@ src/tga_cvt.sv @@
// ----------------------------------------------------------------------------
// tga_cvt
// Converts a gathered pixel word of the configured format to RGBA.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_cvt
   import tga_pkg::*;
(
   input  wire logic [2:0]  format,
   input  wire logic [31:0] pixel,
   output rgba_type         color
);

   logic [7:0]  b0, b1, b2, b3;
   logic [15:0] c16;

   assign b0  = pixel[7:0];
   assign b1  = pixel[15:8];
   assign b2  = pixel[23:16];
   assign b3  = pixel[31:24];
   assign c16 = {b1, b0};

   // per-format channel mapping
   always_comb begin
      unique case (format)
         FMT_GREY8: begin
            color = '{red: b0, green: b0, blue: b0, alpha: 8'hFF};
         end
         FMT_GREY16: begin
            color = '{red: b0, green: b0, blue: b0, alpha: b1};
         end
         FMT_ARGB1555: begin
            color.red   = scale5(c16[14:10]);
            color.green = scale5(c16[9:5]);
            color.blue  = scale5(c16[4:0]);
            color.alpha = c16[15] ? 8'h00 : 8'hFF;
         end
         FMT_BGRA32: begin
            color = '{red: b2, green: b1, blue: b0, alpha: b3};
         end
         default: begin
            color = '{red: b2, green: b1, blue: b0, alpha: 8'hFF};
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/tga_core.sv @@
// ----------------------------------------------------------------------------
// tga_core
// Packet parser, pixel byte gathering and image pixel counting.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_core
   import tga_pkg::*;
#(
   parameter int COUNT_BITS = 25
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [7:0]            data_byte,
   input  wire logic [2:0]            pixel_format,
   input  wire logic                  rle_enable,
   input  wire logic [COUNT_BITS-1:0] pixel_count,
   output pix_result_type             result
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             packet_left_ff, packet_left_in;
   logic [1:0]             byte_idx_ff, byte_idx_in;
   logic [31:0]            pixel_bytes_ff, pixel_bytes_in;
   logic [COUNT_BITS-1:0]  pixels_done_ff, pixels_done_in;

   logic                   image_done;
   logic                   in_packet;
   logic [31:0]            merged;
   logic [2:0]             bpp;
   logic [COUNT_BITS-1:0]  remaining;
   logic [7:0]             left_dec;

   assign image_done = pixels_done_ff >= pixel_count;
   assign in_packet  = (phase_ff == PH_RUN) || (phase_ff == PH_RAW);
   assign bpp        = bytes_per_pixel(pixel_format);
   assign remaining  = pixel_count - pixels_done_ff;
   assign left_dec   = packet_left_ff - 8'd1;

   // drop the new byte into its slot of the pixel word
   always_comb begin
      merged = pixel_bytes_ff;
      unique case (byte_idx_ff)
         2'd0:    merged[7:0]   = data_byte;
         2'd1:    merged[15:8]  = data_byte;
         2'd2:    merged[23:16] = data_byte;
         default: merged[31:24] = data_byte;
      endcase
   end

   // next state and result for the byte at the input register
   always_comb begin
      phase_in          = phase_ff;
      packet_left_in    = packet_left_ff;
      byte_idx_in       = byte_idx_ff;
      pixel_bytes_in    = pixel_bytes_ff;
      pixels_done_in    = pixels_done_ff;
      result.emit       = 1'b0;
      result.format     = pixel_format;
      result.pixel      = merged;
      result.repeat_cnt = 8'd1;
      result.clipped    = 1'b0;
      result.last       = 1'b0;
      if (advance && !image_done) begin
         if (rle_enable && !in_packet) begin
            // packet header byte
            packet_left_in = {1'b0, data_byte[6:0]} + 8'd1;
            phase_in       = data_byte[7] ? PH_RUN : PH_RAW;
            byte_idx_in    = 2'd0;
            pixel_bytes_in = '0;
         end else if (({1'b0, byte_idx_ff} + 3'd1) < bpp) begin
            // more bytes of this pixel to come
            byte_idx_in    = byte_idx_ff + 2'd1;
            pixel_bytes_in = merged;
         end else begin
            // pixel complete
            byte_idx_in    = 2'd0;
            pixel_bytes_in = '0;
            result.emit    = 1'b1;
            if (rle_enable) begin
               if (phase_ff == PH_RUN) begin
                  if (COUNT_BITS'(packet_left_ff) > remaining) begin
                     result.repeat_cnt = remaining[7:0];
                     result.clipped    = 1'b1;
                  end else begin
                     result.repeat_cnt = packet_left_ff;
                  end
                  packet_left_in = 8'd0;
                  phase_in       = PH_HEADER;
               end else begin
                  result.clipped = (remaining == COUNT_BITS'(1)) &&
                                   (packet_left_ff > 8'd1);
                  packet_left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            result.last    = COUNT_BITS'(result.repeat_cnt) == remaining;
            pixels_done_in = pixels_done_ff + COUNT_BITS'(result.repeat_cnt);
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         packet_left_ff <= 8'd0;
         byte_idx_ff    <= 2'd0;
         pixel_bytes_ff <= '0;
         pixels_done_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         byte_idx_ff    <= byte_idx_in;
         pixel_bytes_ff <= pixel_bytes_in;
         pixels_done_ff <= pixels_done_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Targa pixel-data decoder. Bytes go in through a
// bursty valid/stall sender while the pixel port stalls on its own pattern. A
// local decoder model predicts each pixel and its repeat, clipped and last
// flags. Directed tests come first, then randomized images of mixed format and
// packet coding.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import tga_pkg::*;

   localparam int COUNT_BITS    = 25;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_BYTES  = 1000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_res;
      logic       clipped;
      logic       last;
   } pixel_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // dut ports
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_index = CSR_PIXEL_FORMAT;
   logic [COUNT_BITS-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_red;
   logic [7:0]            rsp_green;
   logic [7:0]            rsp_blue;
   logic [7:0]            rsp_alpha;
   logic [7:0]            rsp_repeat_res;
   logic                  rsp_clipped;
   logic                  rsp_last;

   tga_rle_pixel_decoder #(.COUNT_BITS(COUNT_BITS)) uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_clipped    (rsp_clipped),
      .rsp_last       (rsp_last)
   );

   // decoder model state
   logic [2:0]            fmt_reg;
   logic                  rle_reg;
   logic [COUNT_BITS-1:0] count_reg;
   phase_type             phase;
   logic [7:0]            packet_left;
   logic [1:0]            byte_pos;
   logic [31:0]           pixel_word;
   logic [COUNT_BITS-1:0] pixels_out;

   pixel_type expected_pixels[$];

   // bookkeeping
   int failures      = 0;
   int bytes_sent    = 0;
   int bytes_decoded = 0;
   int pixels_seen   = 0;
   int clipped_seen  = 0;
   int images_seen   = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   int stall_mode    = 0;
   int stall_timer   = 0;

   function automatic int fmt_bytes(input logic [2:0] fmt);
      case (fmt)
         FMT_GREY8:    return 1;
         FMT_GREY16:   return 2;
         FMT_ARGB1555: return 2;
         FMT_BGRA32:   return 4;
         default:      return 3;
      endcase
   endfunction

   // 5-bit channel widened to 0..255, rounded down
   function automatic logic [7:0] widen5(input logic [4:0] x);
      int v;
      v = (int'(x) * 255) / 31;
      return v[7:0];
   endfunction

   task automatic reset_decoder();
      fmt_reg     = FORMAT_RESET;
      rle_reg     = 1'b0;
      count_reg   = COUNT_BITS'(1);
      phase       = PH_HEADER;
      packet_left = 8'd0;
      byte_pos    = 2'd0;
      pixel_word  = 32'd0;
      pixels_out  = '0;
   endtask

   // one accepted byte through the model; queues a pixel when one completes
   task automatic decode_byte(input logic [7:0] b);
      logic [COUNT_BITS-1:0] remaining;
      logic [COUNT_BITS-1:0] rep;
      logic                  clip;
      logic [15:0]           c;
      pixel_type             px;

      if (pixels_out >= count_reg) return;
      bytes_decoded++;

      // packet header byte
      if (rle_reg && phase != PH_RUN && phase != PH_RAW) begin
         packet_left = {1'b0, b[6:0]} + 8'd1;
         phase = b[7] ? PH_RUN : PH_RAW;
         byte_pos = 2'd0;
         pixel_word = 32'd0;
         return;
      end

      // gather the pixel bytes
      pixel_word[byte_pos*8 +: 8] = b;
      if (int'(byte_pos) + 1 < fmt_bytes(fmt_reg)) begin
         byte_pos = byte_pos + 2'd1;
         return;
      end
      byte_pos = 2'd0;

      // repeat count and end-of-image flags
      remaining = count_reg - pixels_out;
      rep = COUNT_BITS'(1);
      clip = 1'b0;
      if (rle_reg) begin
         if (phase == PH_RUN) begin
            rep = COUNT_BITS'(packet_left);
            if (rep > remaining) begin
               rep = remaining;
               clip = 1'b1;
            end
            packet_left = 8'd0;
            phase = PH_HEADER;
         end else begin
            if (remaining == COUNT_BITS'(1) && packet_left > 8'd1) clip = 1'b1;
            packet_left = packet_left - 8'd1;
            if (packet_left == 8'd0) phase = PH_HEADER;
         end
      end

      // color conversion
      c = pixel_word[15:0];
      case (fmt_reg)
         FMT_GREY8: begin
            px.red = pixel_word[7:0];
            px.green = pixel_word[7:0];
            px.blue = pixel_word[7:0];
            px.alpha = 8'd255;
         end
         FMT_GREY16: begin
            px.red = pixel_word[7:0];
            px.green = pixel_word[7:0];
            px.blue = pixel_word[7:0];
            px.alpha = pixel_word[15:8];
         end
         FMT_ARGB1555: begin
            px.red = widen5(c[14:10]);
            px.green = widen5(c[9:5]);
            px.blue = widen5(c[4:0]);
            px.alpha = c[15] ? 8'd0 : 8'd255;
         end
         FMT_BGRA32: begin
            px.red = pixel_word[23:16];
            px.green = pixel_word[15:8];
            px.blue = pixel_word[7:0];
            px.alpha = pixel_word[31:24];
         end
         default: begin
            px.red = pixel_word[23:16];
            px.green = pixel_word[15:8];
            px.blue = pixel_word[7:0];
            px.alpha = 8'd255;
         end
      endcase
      px.repeat_res = rep[7:0];
      px.clipped = clip;
      px.last = (rep == remaining);
      pixels_out = pixels_out + rep;
      pixel_word = 32'd0;
      expected_pixels.push_back(px);
   endtask

   // model follows register writes and accepted bytes
   always @(posedge clock) begin
      if (reset) begin
         reset_decoder();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PIXEL_FORMAT: fmt_reg = csr_wdata[2:0];
               CSR_RLE_ENABLE:   rle_reg = csr_wdata[0];
               CSR_PIXEL_COUNT:  count_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // pixel checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel: rgba %0d %0d %0d %0d repeat %0d",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_res);
            failures++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
            check_field("repeat_res", want.repeat_res, rsp_repeat_res);
            check_field("clipped", want.clipped, rsp_clipped);
            check_field("last", want.last, rsp_last);
            pixels_seen++;
            if (rsp_clipped) clipped_seen++;
            if (rsp_last) images_seen++;
         end
      end
   end

   // receiver stall pattern, switching to a random mode whenever its timer runs out
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_timer = $urandom_range(50, 300);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((stall_timer % 8) < 3);
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one item over the input port, in bursts with random gaps
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 64);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // stop sending and wait until every expected pixel has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [COUNT_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // image end placed n pixels past what has been decoded so far
   task automatic start_image(input int n);
      write_reg(CSR_PIXEL_COUNT, pixels_out + COUNT_BITS'(n));
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel();
      repeat (fmt_bytes(fmt_reg)) send_byte(rand_byte());
   endtask

   // reset registers: bgr24, no rle, one pixel, then the image is done
   task automatic test_reset_defaults();
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      drain();
   endtask

   // a pixel of each format (two of argb1555), with bgr24 through an out-of-range code
   task automatic test_formats();
      write_reg(CSR_RLE_ENABLE, COUNT_BITS'(1'b0));
      start_image(100);
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_GREY8));
      send_byte(8'hFF);
      drain();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_GREY16));
      send_byte(8'h80);
      send_byte(8'h00);
      drain();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_ARGB1555));
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h1F);
      send_byte(8'h7C);
      drain();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_BGRA32));
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'hFE);
      send_byte(8'h7F);
      drain();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(3'd7));
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(8'h30);
      drain();
   endtask

   // longest run, raw packet, run and raw packet cut at the image end
   task automatic test_packets();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_GREY8));
      write_reg(CSR_RLE_ENABLE, COUNT_BITS'(1'b1));
      start_image(200);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hAA);
      drain();
      start_image(3);
      send_byte(8'h85);
      send_byte(8'h66);
      send_byte(8'h80);
      drain();
      start_image(1);
      send_byte(8'h03);
      send_byte(8'h77);
      drain();
      write_reg(CSR_PIXEL_COUNT, '0);
      send_byte(8'h81);
      drain();
   endtask

   // rle switched off inside a raw packet, format switched inside a pixel
   task automatic test_mid_changes();
      start_image(20);
      send_byte(8'h04);
      send_byte(8'h3C);
      drain();
      write_reg(CSR_RLE_ENABLE, COUNT_BITS'(1'b0));
      send_byte(8'hC3);
      drain();
      write_reg(CSR_RLE_ENABLE, COUNT_BITS'(1'b1));
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_BGRA32));
      send_byte(8'h12);
      send_byte(8'h34);
      drain();
      write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'(FMT_GREY16));
      send_byte(8'h56);
      drain();
   endtask

   // random images: mostly well-formed packets, some stray bytes
   task automatic test_random_images();
      int            budget;
      int            first;
      logic [7:0]    hdr;
      logic [COUNT_BITS-1:0] target;

      while (bytes_sent < RANDOM_BYTES) begin
         drain();
         write_reg(CSR_PIXEL_FORMAT, COUNT_BITS'($urandom_range(0, 7)));
         write_reg(CSR_RLE_ENABLE, COUNT_BITS'($urandom_range(0, 3) != 0));
         case ($urandom_range(0, 19))
            0: target = '0;
            1: target = COUNT_BITS'(16777216);
            2: target = '1;
            3: target = pixels_out + COUNT_BITS'(1);
            default: target = pixels_out + COUNT_BITS'($urandom_range(2, 150));
         endcase
         write_reg(CSR_PIXEL_COUNT, target);
         budget = $urandom_range(8, 100);
         first = bytes_sent;
         while (bytes_sent - first < budget) begin
            if ($urandom_range(0, 15) == 0) begin
               send_byte(rand_byte());
            end else if (rle_reg) begin
               hdr[7] = 1'($urandom_range(0, 1));
               hdr[6:0] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(0, 7));
               send_byte(hdr);
               if (hdr[7]) send_pixel();
               else repeat (int'(hdr[6:0]) + 1) send_pixel();
            end else begin
               send_pixel();
            end
         end
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_formats();
      test_packets();
      test_mid_changes();
      test_random_images();

      repeat (10) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never came out", expected_pixels.size());
         failures++;
      end
      $display("covered %0d bytes sent, %0d decoded, %0d pixels checked",
               bytes_sent, bytes_decoded, pixels_seen);
      $display("%0d clipped runs, %0d completed images, %0d mismatches",
               clipped_seen, images_seen, failures);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
